// File: hw/rtl/bbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_pkg: shared constants and types of the RGB box blur
// Register indexes, geometry limits and the packed pixel type.
// ----------------------------------------------------------------------------
package bbf_pkg;
    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int MaxBox    = 16;
    localparam int WW  = $clog2(MaxWidth) + 1;   // width/height register bits
    localparam int CW  = $clog2(MaxWidth);        // column index bits
    localparam int RW  = $clog2(MaxHeight);       // row index bits
    localparam int BW  = $clog2(MaxBox) + 1;      // box register bits
    localparam int SW  = $clog2(MaxBox);          // row slot bits
    localparam int CSW = 12;                      // column sum per channel
    localparam int WSW = 16;                      // window sum per channel
    localparam int AW  = 2 * BW;                  // box area bits
    localparam int DW  = WSW + 1;                 // divider remainder bits

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROWS   = 2'd2;
    localparam logic [1:0] REG_COLS   = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [WSW-1:0] red;
        logic [WSW-1:0] green;
        logic [WSW-1:0] blue;
    } t_wsum;

    function automatic logic [WW-1:0] clamp_dim(input logic [11:0] v);
        logic [WW-1:0] r;
        if (v == 12'd0) r = WW'(1);
        else if (int'(v) > MaxWidth) r = WW'(MaxWidth);
        else r = WW'(v);
        return r;
    endfunction

    function automatic logic [BW-1:0] clamp_box(input logic [4:0] v);
        logic [BW-1:0] r;
        if (v == 5'd0) r = BW'(1);
        else if (int'(v) > MaxBox) r = BW'(MaxBox);
        else r = BW'(v);
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/bbf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_div: three-channel restoring divider
// Divides three window sums by the box area, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbf_div
    import bbf_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_wsum         i_sum,
    input  wire logic [AW-1:0] i_area,
    output logic               o_busy,
    output logic               o_done,
    output t_pix               o_mean
);
    localparam int CNW = $clog2(WSW + 1);

    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [AW-1:0]  r_area;
    logic [WSW-1:0] r_q [3];
    logic [DW-1:0]  r_rem [3];
    logic [WSW-1:0] n_q [3];
    logic [DW-1:0]  n_rem [3];

    always_comb begin
        logic [DW-1:0] sh;
        for (int c = 0; c < 3; c++) begin
            sh = {r_rem[c][DW-2:0], r_q[c][WSW-1]};
            if (sh >= DW'(r_area)) begin
                n_rem[c] = sh - DW'(r_area);
                n_q[c]   = {r_q[c][WSW-2:0], 1'b1};
            end else begin
                n_rem[c] = sh;
                n_q[c]   = {r_q[c][WSW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(WSW);
                r_area <= i_area;
                r_q[0] <= i_sum.red;
                r_q[1] <= i_sum.green;
                r_q[2] <= i_sum.blue;
                for (int c = 0; c < 3; c++) r_rem[c] <= '0;
            end else if (r_busy) begin
                for (int c = 0; c < 3; c++) begin
                    r_q[c]   <= n_q[c];
                    r_rem[c] <= n_rem[c];
                end
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_mean = '{red: r_q[0][7:0], green: r_q[1][7:0], blue: r_q[2][7:0]};
endmodule
`default_nettype wire

// File: hw/rtl/box_blur_filter_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_filter_rgb: valid-region RGB box blur
// Streams RGB pixels in raster order and gives per-channel box means.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one pixel a beat in raster order.
//   Output channel (o_valid/i_ready) carries one mean a beat for every box
//   that fits in the frame; o_last_of_frame marks the final one.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken at
//   any time; geometry is latched at the first pixel of each frame.
//   A pixel that makes no result passes through accept, memory read,
//   modify and write back before the next one is accepted. A pixel that
//   makes a result also runs the bit-serial divider; the next pixel is
//   accepted only once the mean is registered. The block works on one
//   pixel at a time.
//   The result sits in an output register; the next pixel is accepted while
//   it waits, and the block stalls only when a new result finds it full.
//   Reset clears all control state and restores the reset geometry; the
//   memories need no clearing, the first row of a frame overwrites them.
// ----------------------------------------------------------------------------
module box_blur_filter_rgb
    import bbf_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_in_red,
    input  wire logic [7:0]   i_in_green,
    input  wire logic [7:0]   i_in_blue,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [7:0]        o_out_red,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_blue,
    output logic              o_last_of_frame,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [11:0]  i_cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_DIV, S_OUT} t_state;

    // configuration
    logic [11:0] r_cfg_w, r_cfg_h;
    logic [4:0]  r_cfg_br, r_cfg_bc;
    logic [WW-1:0] r_w, r_h;
    logic [BW-1:0] r_br, r_bc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 12'd640;
            r_cfg_h  <= 12'd480;
            r_cfg_br <= 5'd3;
            r_cfg_bc <= 5'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_w  <= i_cfg_data;
                REG_HEIGHT: r_cfg_h  <= i_cfg_data;
                REG_ROWS:   r_cfg_br <= i_cfg_data[4:0];
                REG_COLS:   r_cfg_bc <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // memories: pixel rows and column sums
    localparam int PAW = SW + CW;
    t_pix              m_rows [MaxBox * MaxWidth];
    logic [3*CSW-1:0]  m_cols [MaxWidth];
    t_pix              r_old_rd;
    logic [3*CSW-1:0]  r_col_rd;
    logic              r_row_we, r_col_we;
    logic [PAW-1:0]    r_row_wa;
    logic [CW-1:0]     r_col_wa;
    t_pix              r_row_wd;
    logic [3*CSW-1:0]  r_col_wd;
    logic [PAW-1:0]    n_old_ra;

    always_ff @(posedge i_clk) begin
        if (r_row_we) m_rows[r_row_wa] <= r_row_wd;
        r_old_rd <= m_rows[n_old_ra];
    end
    always_ff @(posedge i_clk) begin
        if (r_col_we) m_cols[r_col_wa] <= r_col_wd;
        r_col_rd <= m_cols[r_col_wa];
    end

    // pipeline control
    t_state        r_state;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    t_pix          r_pix;
    logic [3*CSW-1:0] r_recent [MaxBox];
    t_wsum         r_win;
    logic          r_last;
    logic          r_have;
    logic          r_div_go;
    logic [AW-1:0] r_area;
    logic          r_ov;
    t_pix          r_om;
    logic          r_ol;
    logic          div_busy, div_done;
    t_pix          div_mean;

    // geometry for this beat: latch at frame start
    logic [WW-1:0] g_w, g_h;
    logic [BW-1:0] g_br, g_bc;
    logic          frame_start;
    assign frame_start = (r_row == '0) && (r_col == '0);
    assign g_w  = frame_start ? clamp_dim(r_cfg_w)  : r_w;
    assign g_h  = frame_start ? clamp_dim(r_cfg_h)  : r_h;
    assign g_br = frame_start ? clamp_box(r_cfg_br) : r_br;
    assign g_bc = frame_start ? clamp_box(r_cfg_bc) : r_bc;

    logic [RW-1:0] old_row;
    assign old_row = r_row - RW'(r_br);
    assign n_old_ra = {old_row[SW-1:0], r_col};

    // a waiting result holds back the input only when a new result needs the divider
    assign o_ready = (r_state == S_IDLE);
    logic in_fire;
    assign in_fire = i_valid && o_ready;

    // CALC stage arithmetic
    logic [CSW-1:0] csum_old [3], csum_new [3], rec_old [3];
    logic [7:0]     pv [3], ov [3];
    logic [WSW-1:0] wv [3], wn [3];
    logic           has_old, drop_col;
    logic [CW-1:0]  drop_idx;
    always_comb begin
        has_old  = r_row >= RW'(r_br);
        drop_col = r_col >= CW'(r_bc);
        drop_idx = r_col - CW'(r_bc);
        pv[0] = r_pix.red;   pv[1] = r_pix.green;   pv[2] = r_pix.blue;
        ov[0] = r_old_rd.red; ov[1] = r_old_rd.green; ov[2] = r_old_rd.blue;
        wv[0] = r_win.red;   wv[1] = r_win.green;   wv[2] = r_win.blue;
        for (int c = 0; c < 3; c++) begin
            csum_old[c] = r_col_rd[(2-c)*CSW +: CSW];
            rec_old[c]  = r_recent[drop_idx[SW-1:0]][(2-c)*CSW +: CSW];
            if (r_row == '0) csum_new[c] = CSW'(pv[c]);
            else csum_new[c] = csum_old[c] + CSW'(pv[c])
                               - (has_old ? CSW'(ov[c]) : CSW'(0));
            wn[c] = ((r_col == '0) ? WSW'(0) : wv[c]) + WSW'(csum_new[c])
                    - (drop_col ? WSW'(rec_old[c]) : WSW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_w      <= clamp_dim(12'd640);
            r_h      <= clamp_dim(12'd480);
            r_br     <= clamp_box(5'd3);
            r_bc     <= clamp_box(5'd3);
            r_row_we <= 1'b0;
            r_col_we <= 1'b0;
            r_div_go <= 1'b0;
            r_ov     <= 1'b0;
            r_win    <= '0;
        end else begin
            r_row_we <= 1'b0;
            r_col_we <= 1'b0;
            r_div_go <= 1'b0;
            if (o_valid && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_w  <= g_w;  r_h  <= g_h;
                        r_br <= g_br; r_bc <= g_bc;
                        r_pix    <= '{red: i_in_red, green: i_in_green, blue: i_in_blue};
                        r_col_wa <= r_col;  // read column sum at this address
                        r_state  <= S_READ;
                    end
                end
                S_READ: r_state <= S_CALC;  // memory reads land now
                S_CALC: begin
                    r_row_we <= 1'b1;
                    r_row_wa <= {r_row[SW-1:0], r_col};
                    r_row_wd <= r_pix;
                    r_col_we <= 1'b1;
                    r_col_wd <= {csum_new[0], csum_new[1], csum_new[2]};
                    r_recent[r_col[SW-1:0]] <= {csum_new[0], csum_new[1], csum_new[2]};
                    r_win    <= '{red: wn[0], green: wn[1], blue: wn[2]};
                    r_have   <= ({1'b0, r_row} + 1'b1 >= (RW+1)'(r_br)) &&
                                ({1'b0, r_col} + 1'b1 >= (CW+1)'(r_bc));
                    r_last   <= ({1'b0, r_row} + 1'b1 == (RW+1)'(r_h)) &&
                                ({1'b0, r_col} + 1'b1 == (CW+1)'(r_w));
                    r_area   <= AW'(r_br) * AW'(r_bc);
                    if ({1'b0, r_col} + 1'b1 >= (CW+1)'(r_w)) begin
                        r_col <= '0;
                        if ({1'b0, r_row} + 1'b1 >= (RW+1)'(r_h)) r_row <= '0;
                        else r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!r_have) r_state <= S_IDLE;
                    else if (!r_ov) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (div_done) begin
                        r_ov    <= 1'b1;
                        r_om    <= div_mean;
                        r_ol    <= r_last;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    bbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_sum   (r_win),
        .i_area  (r_area),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_mean  (div_mean)
    );

    assign o_valid         = r_ov;
    assign o_out_red       = r_om.red;
    assign o_out_green     = r_om.green;
    assign o_out_blue      = r_om.blue;
    assign o_last_of_frame = r_ol;

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_red)))
        else $error("pending result changed");
    // input is taken only with the pipeline empty
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_state == S_IDLE && !div_busy))
        else $error("pixel accepted while busy");
    // divider starts only with a free output register
    a_div_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !r_ov)
        else $error("divider started with output full");
endmodule
`default_nettype wire
